// File: rtl/core/assert_macros.svh
// Assertion macros shared by the classifier RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LLKC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LLKC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/llkc_pkg.sv
// Package for the log line keyword classifier: payload types, keyword table,
// result codes and the cell control struct. No dependencies.
package llkc_pkg;

	localparam int HistDepth = 11;
	localparam int KeyCount  = 7;
	localparam int KeyMaxLen = HistDepth + 1;
	localparam int WinBits   = KeyMaxLen * 8;

	typedef logic [7:0]          byte_t;
	typedef logic [KeyCount-1:0] flags_t;
	typedef logic [WinBits-1:0]  window_t;

	typedef enum logic {
		KIND_TEXT = 1'b0,
		KIND_EOL  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		THREAT_NONE         = 2'd0,
		THREAT_CVE          = 2'd1,
		THREAT_UNAUTHORIZED = 2'd2,
		THREAT_MALICIOUS    = 2'd3
	} threat_t;

	typedef enum logic [2:0] {
		TECH_UNKNOWN    = 3'd0,
		TECH_MIMIKATZ   = 3'd1,
		TECH_PING       = 3'd2,
		TECH_POWERSHELL = 3'd3,
		TECH_WHOAMI     = 3'd4
	} technique_t;

	// Flag bit positions.
	localparam int KeyCve          = 0;
	localparam int KeyUnauthorized = 1;
	localparam int KeyMalicious    = 2;
	localparam int KeyMimikatz     = 3;
	localparam int KeyPing         = 4;
	localparam int KeyPowershell   = 5;
	localparam int KeyWhoami       = 6;

	// Keywords right-aligned: last character in bits [7:0], zero padded above.
	localparam window_t KeyText [KeyCount] = '{
		window_t'("CVE"),
		window_t'("unauthorized"),
		window_t'("malicious"),
		window_t'("mimikatz"),
		window_t'("ping"),
		window_t'("powershell"),
		window_t'("whoami")
	};

	// Compare masks covering exactly the keyword length.
	localparam window_t KeyMask [KeyCount] = '{
		window_t'({3{8'hFF}}),
		window_t'({12{8'hFF}}),
		window_t'({9{8'hFF}}),
		window_t'({8{8'hFF}}),
		window_t'({4{8'hFF}}),
		window_t'({10{8'hFF}}),
		window_t'({6{8'hFF}})
	};

	typedef struct packed {
		kind_t kind;
		byte_t byte_value;
	} line_item_t;

	typedef struct packed {
		threat_t    threat_code;
		technique_t technique_code;
	} verdict_t;

	// Per-cycle control for the history cells.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

// File: rtl/core/llkc_stream_if.sv
// Valid/ready stream channel carrying one payload of type T per transfer.
// No dependencies; the payload type is supplied by the instantiating code.
interface llkc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/llkc_cell.sv
// One history cell: holds a byte, takes din (the neighbor's or incoming byte)
// on each text transfer and clears at end of line. Depends on llkc_pkg.
module llkc_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  llkc_pkg::cell_ctl_t ctl,
	input  llkc_pkg::byte_t   din,
	output llkc_pkg::byte_t   dout
);
	import llkc_pkg::*;

	byte_t byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
endmodule

// File: rtl/core/llkc_match.sv
// Keyword compare over the twelve-byte window (history plus incoming byte).
// Depends on llkc_pkg for the keyword table and masks.
module llkc_match (
	input  llkc_pkg::window_t win,
	output llkc_pkg::flags_t  hits
);
	import llkc_pkg::*;

	always_comb begin
		hits = '0;
		for (int k = 0; k < KeyCount; k++) begin
			hits[k] = ((win ^ KeyText[k]) & KeyMask[k]) == '0;
		end
	end
endmodule

// File: rtl/core/log_line_keyword_classifier_top.sv
// Log line keyword classifier, top level.
// Channels: line (sink) takes one item per transfer: kind = text byte or end
// of line, byte_value = the character. verdict (source) gives one item per
// end of line: threat_code and technique_code.
// A row of eleven byte cells holds the recent history; each text byte is
// matched against all seven keywords in the cycle it arrives and sets sticky
// flags. The end-of-line item turns the flags into codes, registered as the
// verdict, and clears flags and cells.
// Throughput: one item per cycle while line.ready is high, text or end of
// line, set by the single cell shift per transfer. The verdict is registered
// in the output register, or in the skid register while the output is held.
// Stall: a verdict held by a stalled receiver does not stop input; a second
// verdict waits in a skid register, and line.ready drops only while both
// verdict registers are full.
// Reset: arst_n clears cells, flags and the valid bits of both verdict
// registers at once; the block takes items in the first cycle after reset.
// Depends on llkc_pkg, llkc_stream_if, llkc_cell, llkc_match.
`include "assert_macros.svh"

module log_line_keyword_classifier_top (
	input  logic clk,
	input  logic arst_n,
	llkc_stream_if.sink   line,
	llkc_stream_if.source verdict
);
	import llkc_pkg::*;

	line_item_t item;
	logic       take;
	logic       take_eol;
	cell_ctl_t  ctl;
	byte_t      cell_byte [HistDepth];
	window_t    win;
	flags_t     hits;
	flags_t     flags_q;
	verdict_t   result;
	verdict_t   out_q;
	verdict_t   skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       pop;

	assign item      = line.payload;
	assign line.ready = !skid_valid_q;
	assign take      = line.valid && line.ready;
	assign take_eol  = take && (item.kind == KIND_EOL);
	assign ctl.shift = take && (item.kind == KIND_TEXT);
	assign ctl.clear = take_eol;

	for (genvar i = 0; i < HistDepth; i++) begin : g_cell
		if (i == 0) begin : g_head
			llkc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.din    (item.byte_value),
				.dout   (cell_byte[i])
			);
		end else begin : g_body
			llkc_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.din    (cell_byte[i-1]),
				.dout   (cell_byte[i])
			);
		end
		assign win[8*(i+1) +: 8] = cell_byte[i];
	end
	assign win[7:0] = item.byte_value;

	llkc_match u_match (
		.win  (win),
		.hits (hits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (take_eol) begin
			flags_q <= '0;
		end else if (ctl.shift) begin
			flags_q <= flags_q | hits;
		end
	end

	// Priority encode the flags into the two codes.
	always_comb begin
		if (flags_q[KeyCve]) begin
			result.threat_code = THREAT_CVE;
		end else if (flags_q[KeyUnauthorized]) begin
			result.threat_code = THREAT_UNAUTHORIZED;
		end else if (flags_q[KeyMalicious]) begin
			result.threat_code = THREAT_MALICIOUS;
		end else begin
			result.threat_code = THREAT_NONE;
		end
		if (flags_q[KeyMimikatz]) begin
			result.technique_code = TECH_MIMIKATZ;
		end else if (flags_q[KeyPing]) begin
			result.technique_code = TECH_PING;
		end else if (flags_q[KeyPowershell]) begin
			result.technique_code = TECH_POWERSHELL;
		end else if (flags_q[KeyWhoami]) begin
			result.technique_code = TECH_WHOAMI;
		end else begin
			result.technique_code = TECH_UNKNOWN;
		end
	end

	assign pop = out_valid_q && verdict.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (take_eol) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload registers: advance from skid, or load a fresh verdict.
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (take_eol) begin
			if (!out_valid_q || pop) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.payload = out_q;

	`LLKC_ASSERT_SAME(a_skid_needs_out, skid_valid_q, out_valid_q,
		"skid holds a verdict while the output register is empty")
	`LLKC_ASSERT_NEXT(a_eol_clears_flags, take_eol, flags_q == '0,
		"keyword flags not cleared after end of line")
	`LLKC_ASSERT_NEXT(a_eol_gives_verdict, take_eol && !out_valid_q, out_valid_q,
		"end of line transfer did not produce a verdict")
	`LLKC_ASSERT_NEXT(a_skid_drains, skid_valid_q && pop, out_valid_q && !skid_valid_q,
		"skid verdict not moved to the output register")
endmodule

// File: verif/tb_top.sv
// Self-checking testbench for log_line_keyword_classifier_top: drives lines of text
// over the line channel and checks each verdict against a keyword predictor.
// Depends on llkc_pkg, llkc_stream_if and the classifier RTL.
module tb_top;
	import llkc_pkg::*;

	localparam int RandomItems = 500;
	localparam int CycleLimit  = 200000;

	// Tracks the line history and keyword flags; queues one verdict per end of line.
	class verdict_scoreboard;
		byte_t    history [HistDepth];
		flags_t   seen;
		verdict_t verdict_q [$];
		int       errors;
		int       checked;
		int       flagged;

		function new();
			errors  = 0;
			checked = 0;
			flagged = 0;
			clear_line();
		endfunction

		static function string keyword(int k);
			case (k)
				KeyCve:          return "CVE";
				KeyUnauthorized: return "unauthorized";
				KeyMalicious:    return "malicious";
				KeyMimikatz:     return "mimikatz";
				KeyPing:         return "ping";
				KeyPowershell:   return "powershell";
				default:         return "whoami";
			endcase
		endfunction

		function void clear_line();
			foreach (history[i]) history[i] = '0;
			seen = '0;
		endfunction

		function void note_item(line_item_t it);
			byte_t    win [KeyMaxLen];
			string    kw;
			int       base;
			bit       hit;
			verdict_t v;
			if (it.kind == KIND_TEXT) begin
				for (int i = 0; i < HistDepth; i++) win[i] = history[i];
				win[HistDepth] = it.byte_value;
				// A keyword counts when it ends at the newest byte.
				for (int k = 0; k < KeyCount; k++) begin
					kw   = keyword(k);
					base = KeyMaxLen - kw.len();
					hit  = 1'b1;
					for (int i = 0; i < kw.len(); i++)
						if (win[base + i] != byte_t'(kw[i])) hit = 1'b0;
					if (hit) seen[k] = 1'b1;
				end
				for (int i = 0; i < HistDepth - 1; i++) history[i] = history[i + 1];
				history[HistDepth - 1] = it.byte_value;
			end else begin
				if (seen[KeyCve])               v.threat_code = THREAT_CVE;
				else if (seen[KeyUnauthorized]) v.threat_code = THREAT_UNAUTHORIZED;
				else if (seen[KeyMalicious])    v.threat_code = THREAT_MALICIOUS;
				else                            v.threat_code = THREAT_NONE;
				if (seen[KeyMimikatz])          v.technique_code = TECH_MIMIKATZ;
				else if (seen[KeyPing])         v.technique_code = TECH_PING;
				else if (seen[KeyPowershell])   v.technique_code = TECH_POWERSHELL;
				else if (seen[KeyWhoami])       v.technique_code = TECH_WHOAMI;
				else                            v.technique_code = TECH_UNKNOWN;
				if (seen != '0) flagged++;
				verdict_q.push_back(v);
				clear_line();
			end
		endfunction

		function void check_verdict(verdict_t got);
			verdict_t want;
			checked++;
			if (verdict_q.size() == 0) begin
				$display("%0t: verdict with none pending: threat %0d technique %0d",
					$time, got.threat_code, got.technique_code);
				errors++;
				return;
			end
			want = verdict_q.pop_front();
			if (got.threat_code !== want.threat_code) begin
				$display("%0t: threat_code expected %0d actual %0d",
					$time, want.threat_code, got.threat_code);
				errors++;
			end
			if (got.technique_code !== want.technique_code) begin
				$display("%0t: technique_code expected %0d actual %0d",
					$time, want.technique_code, got.technique_code);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       tx_valid = 1'b0;
	line_item_t tx_item  = '0;
	logic       rx_ready = 1'b0;
	logic [7:0] stall_mask = '0;
	logic [5:0] rx_count   = '0;
	int         cycles     = 0;
	int         items_sent = 0;
	int         lines_sent = 0;
	int         burst_left = 0;
	byte_t      carry_q [$];

	verdict_scoreboard sb;

	llkc_stream_if #(.T(line_item_t)) line_ch ();
	llkc_stream_if #(.T(verdict_t))   verdict_ch ();

	assign line_ch.valid    = tx_valid;
	assign line_ch.payload  = tx_item;
	assign verdict_ch.ready = rx_ready;

	log_line_keyword_classifier_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.line   (line_ch),
		.verdict(verdict_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("timeout after %0d cycles, %0d verdicts pending", cycles,
				sb.verdict_q.size());
			$display("log_line_keyword_classifier_top: mismatch");
			$finish;
		end
	end

	// Receiver: check each verdict transfer, stall on a mask redrawn each time the 6-bit rx_count wraps.
	always @(posedge clk) begin
		if (arst_n && verdict_ch.valid && verdict_ch.ready)
			sb.check_verdict(verdict_ch.payload);
		rx_count <= rx_count + 1'b1;
		if (rx_count == '0) begin
			case ($urandom_range(0, 3))
				0:       stall_mask <= 8'h00;
				1:       stall_mask <= 8'($urandom_range(0, 255));
				2:       stall_mask <= 8'hFE;
				default: stall_mask <= 8'h11;
			endcase
		end
		rx_ready <= ~stall_mask[rx_count[2:0]];
	end

	// Sender: bursts of random length, random idle gaps between them.
	task automatic send_item(kind_t kind, byte_t value);
		line_item_t it;
		int gap;
		it.kind       = kind;
		it.byte_value = value;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				tx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		tx_valid <= 1'b1;
		tx_item  <= it;
		do @(posedge clk); while (!line_ch.ready);
		sb.note_item(it);
		items_sent++;
		burst_left--;
	endtask

	task automatic send_line(byte_t text_q [$]);
		foreach (text_q[i]) send_item(KIND_TEXT, text_q[i]);
		send_item(KIND_EOL, byte_t'($urandom_range(0, 255)));
		lines_sent++;
	endtask

	task automatic push_str(ref byte_t q [$], input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(byte_t'(s[i]));
	endtask

	// Whole keywords amid filler; also near misses, raw bytes and split keywords.
	task automatic random_line();
		byte_t text_q [$];
		string kw;
		int    k;
		int    cut;
		text_q  = carry_q;
		carry_q = {};
		if ($urandom_range(0, 9) != 0) begin
			repeat ($urandom_range(1, 4)) begin
				k  = $urandom_range(0, KeyCount - 1);
				kw = verdict_scoreboard::keyword(k);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: push_str(text_q, kw);
					4: begin
						// flip the case of one letter
						cut = $urandom_range(0, kw.len() - 1);
						for (int i = 0; i < kw.len(); i++)
							text_q.push_back(byte_t'(kw[i]) ^ ((i == cut) ? 8'h20 : 8'h00));
					end
					5: push_str(text_q, kw.substr(0, kw.len() - 2));
					6: repeat ($urandom_range(1, 6))
						text_q.push_back(byte_t'($urandom_range(0, 255)));
					default: repeat ($urandom_range(0, 5))
						text_q.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
				endcase
			end
			// split a keyword over the end of line; the tail opens the next line
			if ($urandom_range(0, 7) == 0) begin
				kw  = verdict_scoreboard::keyword($urandom_range(0, KeyCount - 1));
				cut = $urandom_range(1, kw.len() - 1);
				push_str(text_q, kw.substr(0, cut - 1));
				push_str(carry_q, kw.substr(cut, kw.len() - 1));
			end
		end
		send_line(text_q);
	endtask

	initial begin
		byte_t text_q [$];
		int    directed;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty line, end of line with a random byte, short and full-width keywords
		text_q = {};
		send_line(text_q);
		push_str(text_q, "CVE");
		send_line(text_q);
		text_q = {8'h00, 8'hFF, 8'h00};
		push_str(text_q, "ping");
		send_line(text_q);
		text_q = {};
		push_str(text_q, "unauthorized");
		send_line(text_q);
		directed = items_sent;

		while (items_sent < directed + RandomItems) random_line();
		if (carry_q.size() != 0) random_line();
		tx_valid <= 1'b0;

		while (sb.verdict_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d lines in %0d transfers; checked %0d verdicts, %0d with a keyword",
			lines_sent, items_sent, sb.checked, sb.flagged);
		if (sb.errors == 0) begin
			$display("log_line_keyword_classifier_top: match");
		end else begin
			$display("%0d errors", sb.errors);
			$display("log_line_keyword_classifier_top: mismatch");
		end
		$finish;
	end

endmodule
